>>> hw/rtl/char_lcd_nibble_write_sequencer_defines.svh
// Assertion helpers shared by the sequencer RTL.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LCDSEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define LCDSEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lcdseq_pkg.sv
`timescale 1ns / 1ps

package lcdseq_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_INSTR = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_POWERUP = 3'd0,
    PH_HI_EN   = 3'd1,
    PH_HI_GAP  = 3'd2,
    PH_LO_EN   = 3'd3,
    PH_LO_GAP  = 3'd4,
    PH_POST    = 3'd5,
    PH_IDLE    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    REG_EN_HIGH  = 3'd0,
    REG_EN_LOW   = 3'd1,
    REG_INSTR_WT = 3'd2,
    REG_DATA_WT  = 3'd3,
    REG_CLEAR_WT = 3'd4,
    REG_POWERUP  = 3'd5
  } reg_idx_t;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned COUNT_W = 17;

  localparam logic [7:0] CLEAR_BYTE = 8'h01;

  localparam logic [TICK_W-1:0] RST_EN_HIGH  = 16'd1;
  localparam logic [TICK_W-1:0] RST_EN_LOW   = 16'd100;
  localparam logic [TICK_W-1:0] RST_INSTR_WT = 16'd2000;
  localparam logic [TICK_W-1:0] RST_DATA_WT  = 16'd1000;
  localparam logic [TICK_W-1:0] RST_CLEAR_WT = 16'd2000;
  localparam logic [TICK_W-1:0] RST_POWERUP  = 16'd50000;

  typedef struct packed {
    logic [TICK_W-1:0] enable_high_ticks;
    logic [TICK_W-1:0] enable_low_ticks;
    logic [TICK_W-1:0] instruction_wait_ticks;
    logic [TICK_W-1:0] data_wait_ticks;
    logic [TICK_W-1:0] clear_extra_ticks;
    logic [TICK_W-1:0] powerup_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic       reg_select;
    logic       enable;
    logic [3:0] data_nibble;
    logic       busy_res;
    logic       accepted;
  } lcd_res_t;

  // 4-bit mode bring-up list; entries past the fifth repeat clear
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h02;
      3'd1:    b = 8'h28;
      3'd2:    b = 8'h0C;
      3'd3:    b = 8'h06;
      default: b = CLEAR_BYTE;
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/lcdseq_if.sv
`timescale 1ns / 1ps

interface lcdseq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface lcdseq_out_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic       enable;
  logic [3:0] data_nibble;
  logic       busy_res;
  logic       accepted;

  modport source (output valid, output reg_select, output enable, output data_nibble,
                  output busy_res, output accepted, input ready);
  modport sink (input valid, input reg_select, input enable, input data_nibble,
                input busy_res, input accepted, output ready);
endinterface

>>> hw/rtl/lcdseq_cfg.sv
`timescale 1ns / 1ps

module lcdseq_cfg import lcdseq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [TICK_W-1:0] cfg_wdata,
  output cfg_regs_t         cfg
);

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_EN_HIGH:  cfg_nxt.enable_high_ticks      = cfg_wdata;
        REG_EN_LOW:   cfg_nxt.enable_low_ticks       = cfg_wdata;
        REG_INSTR_WT: cfg_nxt.instruction_wait_ticks = cfg_wdata;
        REG_DATA_WT:  cfg_nxt.data_wait_ticks        = cfg_wdata;
        REG_CLEAR_WT: cfg_nxt.clear_extra_ticks      = cfg_wdata;
        REG_POWERUP:  cfg_nxt.powerup_ticks          = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_high_ticks      <= RST_EN_HIGH;
      cfg_r.enable_low_ticks       <= RST_EN_LOW;
      cfg_r.instruction_wait_ticks <= RST_INSTR_WT;
      cfg_r.data_wait_ticks        <= RST_DATA_WT;
      cfg_r.clear_extra_ticks      <= RST_CLEAR_WT;
      cfg_r.powerup_ticks          <= RST_POWERUP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/lcdseq_engine.sv
`timescale 1ns / 1ps
`include "char_lcd_nibble_write_sequencer_defines.svh"

module lcdseq_engine import lcdseq_pkg::*; #(
  parameter int unsigned INIT_LENGTH = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  cmd_t       cmd,
  input  logic [7:0] value,
  input  cfg_regs_t  cfg,
  output lcd_res_t   res
);

  localparam logic [3:0] InitLen = 4'(INIT_LENGTH);

  phase_t               phase_r, phase_nxt;
  logic [COUNT_W-1:0]   wait_count_r, wait_count_nxt;
  logic [7:0]           held_byte_r, held_byte_nxt;
  logic                 held_select_r, held_select_nxt;
  logic [2:0]           init_step_r, init_step_nxt;
  logic [3:0]           pin_nibble_r, pin_nibble_nxt;
  logic                 init_active_r, init_active_nxt;

  logic [COUNT_W-1:0]   target;
  logic [COUNT_W-1:0]   cnt_inc;
  logic [3:0]           step_inc;
  logic [7:0]           next_init;
  logic                 acc;

  always_comb begin
    unique case (phase_r)
      PH_POWERUP:          target = {1'b0, cfg.powerup_ticks};
      PH_HI_EN, PH_LO_EN:  target = {1'b0, cfg.enable_high_ticks};
      PH_HI_GAP, PH_LO_GAP: target = {1'b0, cfg.enable_low_ticks};
      PH_POST: begin
        if (held_select_r) begin
          target = {1'b0, cfg.data_wait_ticks};
        end else if (held_byte_r == CLEAR_BYTE) begin
          target = {1'b0, cfg.instruction_wait_ticks} + {1'b0, cfg.clear_extra_ticks};
        end else begin
          target = {1'b0, cfg.instruction_wait_ticks};
        end
      end
      default:             target = '0;
    endcase
  end

  assign cnt_inc   = wait_count_r + COUNT_W'(1);
  assign step_inc  = {1'b0, init_step_r} + 4'd1;
  assign next_init = init_byte(step_inc[2:0]);

  always_comb begin
    phase_nxt       = phase_r;
    wait_count_nxt  = wait_count_r;
    held_byte_nxt   = held_byte_r;
    held_select_nxt = held_select_r;
    init_step_nxt   = init_step_r;
    pin_nibble_nxt  = pin_nibble_r;
    init_active_nxt = init_active_r;
    acc             = 1'b0;
    if (go) begin
      case (cmd)
        CMD_TICK: begin
          if (phase_r != PH_IDLE) begin
            wait_count_nxt = cnt_inc;
            if (cnt_inc >= target) begin
              wait_count_nxt = '0;
              unique case (phase_r)
                PH_POWERUP: begin
                  init_step_nxt   = '0;
                  held_byte_nxt   = init_byte(3'd0);
                  held_select_nxt = 1'b0;
                  pin_nibble_nxt  = 4'(init_byte(3'd0) >> 4);
                  phase_nxt       = PH_HI_EN;
                end
                PH_HI_EN:  phase_nxt = PH_HI_GAP;
                PH_HI_GAP: begin
                  pin_nibble_nxt = held_byte_r[3:0];
                  phase_nxt      = PH_LO_EN;
                end
                PH_LO_EN:  phase_nxt = PH_LO_GAP;
                PH_LO_GAP: phase_nxt = PH_POST;
                PH_POST: begin
                  if (init_active_r && (step_inc < InitLen)) begin
                    init_step_nxt   = step_inc[2:0];
                    held_byte_nxt   = next_init;
                    held_select_nxt = 1'b0;
                    pin_nibble_nxt  = next_init[7:4];
                    phase_nxt       = PH_HI_EN;
                  end else begin
                    init_active_nxt = 1'b0;
                    phase_nxt       = PH_IDLE;
                  end
                end
                default:   phase_nxt = PH_IDLE;
              endcase
            end
          end
        end
        CMD_INSTR, CMD_DATA: begin
          if (phase_r == PH_IDLE) begin
            held_byte_nxt   = value;
            held_select_nxt = (cmd == CMD_DATA);
            pin_nibble_nxt  = value[7:4];
            wait_count_nxt  = '0;
            phase_nxt       = PH_HI_EN;
            acc             = 1'b1;
          end
        end
        default: acc = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_POWERUP;
      wait_count_r  <= '0;
      held_byte_r   <= '0;
      held_select_r <= 1'b0;
      init_step_r   <= '0;
      pin_nibble_r  <= '0;
      init_active_r <= 1'b1;
    end else begin
      phase_r       <= phase_nxt;
      wait_count_r  <= wait_count_nxt;
      held_byte_r   <= held_byte_nxt;
      held_select_r <= held_select_nxt;
      init_step_r   <= init_step_nxt;
      pin_nibble_r  <= pin_nibble_nxt;
      init_active_r <= init_active_nxt;
    end
  end

  always_comb begin
    res.reg_select  = held_select_nxt;
    res.enable      = (phase_nxt == PH_HI_EN) || (phase_nxt == PH_LO_EN);
    res.data_nibble = pin_nibble_nxt;
    res.busy_res    = (phase_nxt != PH_IDLE);
    res.accepted    = acc;
  end

  `LCDSEQ_ASSERT_NEXT(a_accept_starts_byte, go && acc, phase_r == PH_HI_EN, "write taken but no high nibble strobe")
  `LCDSEQ_ASSERT_NOW(a_init_done_past_powerup, !init_active_r, phase_r != PH_POWERUP, "init finished yet still in power-up")
  `LCDSEQ_ASSERT_NEXT(a_hold_without_item, !go, $stable(phase_r) && $stable(wait_count_r), "state moved without an item")

endmodule

>>> hw/rtl/char_lcd_nibble_write_sequencer.sv
`timescale 1ns / 1ps
`include "char_lcd_nibble_write_sequencer_defines.svh"
// Channel   Dir  Payload                                                  Transfer
// in_ch     in   command[1:0], value[7:0]                                 valid & ready
// out_ch    out  reg_select, enable, data_nibble[3:0], busy_res, accepted valid & ready
// cfg       in   cfg_index[2:0], cfg_wdata[15:0]                          cfg_we
// One item per cycle sustained while out_ch.ready stays high.
// Path: input register, then phase/counter update in the engine, then the result register.
// Reset (rst_n low at a clock edge) empties both registers and enters the power-up wait.
// A stalled result register holds the input register, which then drops in_ch.ready.
// The engine state advances only when an item moves into the result register.

module char_lcd_nibble_write_sequencer import lcdseq_pkg::*; #(
  parameter int unsigned INIT_LENGTH = 5
) (
  input  logic         clk,
  input  logic         rst_n,
  lcdseq_in_if.sink    in_ch,
  lcdseq_out_if.source out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

  logic       in_valid_r, in_valid_nxt;
  cmd_t       cmd_r;
  logic [7:0] value_r;
  logic       out_valid_r, out_valid_nxt;
  lcd_res_t   res_r;
  lcd_res_t   res;
  cfg_regs_t  cfg;
  logic       step_go;
  logic       in_take;

  assign step_go = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || step_go;
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_valid_nxt  = in_take || (in_valid_r && !step_go);
  assign out_valid_nxt = step_go || (out_valid_r && !out_ch.ready);

  lcdseq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lcdseq_engine #(
    .INIT_LENGTH (INIT_LENGTH)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (step_go),
    .cmd   (cmd_r),
    .value (value_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r   <= cmd_t'(in_ch.command);
      value_r <= in_ch.value;
    end
    if (step_go) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.reg_select  = res_r.reg_select;
  assign out_ch.enable      = res_r.enable;
  assign out_ch.data_nibble = res_r.data_nibble;
  assign out_ch.busy_res    = res_r.busy_res;
  assign out_ch.accepted    = res_r.accepted;

  `LCDSEQ_ASSERT_NEXT(a_step_fills_out, step_go, out_valid_r, "stepped item missing from result register")
  `LCDSEQ_ASSERT_NEXT(a_take_fills_in, in_take, in_valid_r, "transfer lost before the engine")
  `LCDSEQ_ASSERT_NEXT(a_stall_holds_in, in_valid_r && !step_go, in_valid_r && $stable(cmd_r) && $stable(value_r), "waiting item changed")

endmodule

>>> test/char_lcd_nibble_write_sequencer_tb.sv
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer_tb import lcdseq_pkg::*;;

  localparam int unsigned INIT_LEN = 5;

  class lcd_pin_tracker;
    cfg_regs_t           regs;
    phase_t              phase;
    logic [COUNT_W-1:0]  elapsed;
    logic [7:0]          byte_q;
    logic                sel_q;
    logic [2:0]          boot_idx;
    logic [3:0]          pins;
    bit                  booting;
    int unsigned         boot_len;
    logic [7:0]          boot_seq [8];
    lcd_res_t            pins_due [$];
    int unsigned         faults;

    function new(int unsigned len);
      boot_len = len;
      boot_seq = '{8'h02, 8'h28, 8'h0C, 8'h06, CLEAR_BYTE, CLEAR_BYTE, CLEAR_BYTE, CLEAR_BYTE};
      regs = '{RST_EN_HIGH, RST_EN_LOW, RST_INSTR_WT, RST_DATA_WT, RST_CLEAR_WT, RST_POWERUP};
      phase = PH_POWERUP;
      elapsed = '0;
      byte_q = '0;
      sel_q = 1'b0;
      boot_idx = '0;
      pins = '0;
      booting = 1'b1;
      faults = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        REG_EN_HIGH:  regs.enable_high_ticks = v;
        REG_EN_LOW:   regs.enable_low_ticks = v;
        REG_INSTR_WT: regs.instruction_wait_ticks = v;
        REG_DATA_WT:  regs.data_wait_ticks = v;
        REG_CLEAR_WT: regs.clear_extra_ticks = v;
        REG_POWERUP:  regs.powerup_ticks = v;
        default: ;
      endcase
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function void load(logic [7:0] b, logic s);
      byte_q = b;
      sel_q = s;
      pins = b[7:4];
      phase = PH_HI_EN;
      elapsed = '0;
    endfunction

    function logic [COUNT_W-1:0] target();
      logic [COUNT_W-1:0] t;
      case (phase)
        PH_POWERUP:          t = {1'b0, regs.powerup_ticks};
        PH_HI_EN, PH_LO_EN:  t = {1'b0, regs.enable_high_ticks};
        PH_HI_GAP, PH_LO_GAP: t = {1'b0, regs.enable_low_ticks};
        PH_POST: begin
          if (sel_q) begin
            t = {1'b0, regs.data_wait_ticks};
          end else begin
            t = {1'b0, regs.instruction_wait_ticks}
                + ((byte_q == CLEAR_BYTE) ? {1'b0, regs.clear_extra_ticks} : '0);
          end
        end
        default: t = '0;
      endcase
      return t;
    endfunction

    function void close_phase();
      elapsed = '0;
      case (phase)
        PH_POWERUP: begin
          boot_idx = '0;
          load(boot_seq[0], 1'b0);
        end
        PH_HI_EN: phase = PH_HI_GAP;
        PH_HI_GAP: begin
          pins = byte_q[3:0];
          phase = PH_LO_EN;
        end
        PH_LO_EN: phase = PH_LO_GAP;
        PH_LO_GAP: phase = PH_POST;
        PH_POST: begin
          if (booting && (boot_idx + 1) < boot_len) begin
            boot_idx = boot_idx + 3'd1;
            load(boot_seq[boot_idx], 1'b0);
          end else begin
            booting = 1'b0;
            phase = PH_IDLE;
          end
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    // returns 1 when the item changed the sequencer state
    function bit take_item(cmd_t cmd, logic [7:0] v);
      bit       advanced;
      logic     took;
      lcd_res_t r;
      advanced = 1'b0;
      took = 1'b0;
      if (cmd == CMD_TICK) begin
        if (phase != PH_IDLE) begin
          advanced = 1'b1;
          elapsed = elapsed + 1'b1;
          if (elapsed >= target()) close_phase();
        end
      end else if ((cmd == CMD_INSTR || cmd == CMD_DATA) && phase == PH_IDLE) begin
        load(v, cmd == CMD_DATA);
        took = 1'b1;
        advanced = 1'b1;
      end
      r.reg_select = sel_q;
      r.enable = (phase == PH_HI_EN || phase == PH_LO_EN);
      r.data_nibble = pins;
      r.busy_res = (phase != PH_IDLE);
      r.accepted = took;
      pins_due.push_back(r);
      return advanced;
    endfunction

    function void match_pins(lcd_res_t got);
      lcd_res_t want;
      if (pins_due.size() == 0) begin
        $error("result transfer with no expectation pending");
        faults++;
        return;
      end
      want = pins_due.pop_front();
      if (got.reg_select !== want.reg_select) begin
        $error("reg_select: expected %0d, got %0d", want.reg_select, got.reg_select);
        faults++;
      end
      if (got.enable !== want.enable) begin
        $error("enable: expected %0d, got %0d", want.enable, got.enable);
        faults++;
      end
      if (got.data_nibble !== want.data_nibble) begin
        $error("data_nibble: expected %0h, got %0h", want.data_nibble, got.data_nibble);
        faults++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
        faults++;
      end
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
        faults++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  bit          calm = 1'b0;
  bit          squeeze = 1'b0;
  int unsigned moved = 0;

  lcd_pin_tracker tracker = new(INIT_LEN);

  lcdseq_in_if  in_ch ();
  lcdseq_out_if out_ch ();

  char_lcd_nibble_write_sequencer #(.INIT_LENGTH(INIT_LEN)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    lcd_res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.reg_select = out_ch.reg_select;
      got.enable = out_ch.enable;
      got.data_nibble = out_ch.data_nibble;
      got.busy_res = out_ch.busy_res;
      got.accepted = out_ch.accepted;
      tracker.match_pins(got);
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze) begin
        squeeze = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(17, 1)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input cmd_t cmd, input logic [7:0] v);
    if (!calm && $urandom_range(7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    if (tracker.take_item(cmd, v)) moved++;
  endtask

  task automatic settle();
    while (tracker.busy()) send_item(CMD_TICK, 8'($urandom_range(255)));
  endtask

  // send a byte, hit it with a write while busy, then tick it out
  task automatic put_byte(input cmd_t cmd, input logic [7:0] v);
    send_item(cmd, v);
    send_item(($urandom_range(1) != 0) ? CMD_DATA : CMD_INSTR, 8'($urandom_range(255)));
    settle();
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pins_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    tracker.set_reg(idx, v);
  endtask

  task automatic load_regs(input logic [15:0] eh, input logic [15:0] el,
                           input logic [15:0] iw, input logic [15:0] dw,
                           input logic [15:0] ce, input logic [15:0] pu);
    put_reg(REG_EN_HIGH, eh);
    put_reg(REG_EN_LOW, el);
    put_reg(REG_INSTR_WT, iw);
    put_reg(REG_DATA_WT, dw);
    put_reg(REG_CLEAR_WT, ce);
    put_reg(REG_POWERUP, pu);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic chaos(input int unsigned goal);
    int unsigned stop;
    int unsigned r;
    logic [7:0]  v;
    stop = moved + goal;
    while (moved < stop) begin
      r = $urandom_range(99);
      v = 8'($urandom_range(255));
      if (!tracker.busy()) begin
        if (r < 45) send_item(CMD_INSTR, ($urandom_range(4) == 0) ? CLEAR_BYTE : v);
        else if (r < 90) send_item(CMD_DATA, v);
        else if (r < 95) send_item(CMD_TICK, v);
        else send_item(CMD_NONE, v);
      end else begin
        if (r < 88) send_item(CMD_TICK, v);
        else if (r < 95) send_item(($urandom_range(1) != 0) ? CMD_DATA : CMD_INSTR, v);
        else send_item(CMD_NONE, v);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_TICK;
    in_ch.value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    load_regs(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(CMD_INSTR, 8'hFF);
    send_item(CMD_NONE, 8'h00);
    settle();
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_NONE, 8'hFF);
    put_byte(CMD_INSTR, 8'h00);
    put_byte(CMD_DATA, 8'hFF);
    put_byte(CMD_INSTR, CLEAR_BYTE);
    put_byte(CMD_DATA, CLEAR_BYTE);
    put_byte(CMD_INSTR, 8'hF0);
    put_byte(CMD_DATA, 8'h0F);

    // enter the longest waits, then shorten them mid-phase
    drain();
    calm = 1'b1;
    load_regs(16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(CMD_INSTR, CLEAR_BYTE);
    repeat (24) send_item(CMD_TICK, 8'h00);
    drain();
    load_regs(16'd1, 16'd1, 16'd3, 16'hFFFF, 16'd2, 16'd0);
    settle();
    send_item(CMD_DATA, 8'h5A);
    repeat (24) send_item(CMD_TICK, 8'h00);
    drain();
    load_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'd2, 16'd0, 16'd0);
    settle();
    send_item(CMD_INSTR, 8'hA5);
    repeat (24) send_item(CMD_TICK, 8'h00);
    drain();
    load_regs(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
    settle();
    calm = 1'b0;

    for (int unsigned k = 0; k < 9; k++) begin
      drain();
      if (k == 1) begin
        for (int unsigned i = int'(REG_POWERUP) + 1; i < 8; i++) begin
          put_reg(3'(i), 16'($urandom_range(16'hFFFF)));
        end
      end
      load_regs(16'($urandom_range(3, 1)), 16'($urandom_range(3, 1)),
                16'($urandom_range(6)), 16'($urandom_range(6)),
                16'($urandom_range(6)), 16'($urandom_range(16'hFFFF)));
      if (k == 2) squeeze = 1'b1;
      if (k >= 7) calm = 1'b1;
      chaos(130);
    end

    drain();
    if (tracker.faults == 0) begin
      $display("PASS char_lcd_nibble_write_sequencer");
    end else begin
      $display("FAIL char_lcd_nibble_write_sequencer");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAIL char_lcd_nibble_write_sequencer");
    $finish;
  end

endmodule
